[sv/lpfs_pkg.sv]
// ----------------------------------------------------------------------------
// lpfs_pkg
// shared types and constants of the length-prefixed frame splitter
// ----------------------------------------------------------------------------
`default_nettype none

package lpfs_pkg;

  // largest frame length allowed by the system, further capped by the 8-bit counter
  localparam int MaxFrame = 256;
  localparam int LargestLenInt = (MaxFrame - 1 > 255) ? 255 : MaxFrame - 1;
  localparam logic [15:0] LargestLen = 16'(LargestLenInt);

  // frame length is judged once this many bytes are in
  localparam logic [15:0] JudgeCount = 16'd7;

  localparam logic [7:0] StartLen   = 8'hAA;
  localparam logic [7:0] StartTouch = 8'h1F;

  // config register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgTouchEnable = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTouchLen    = 1'd1;
  localparam int CfgDataW = 8;

  localparam logic [7:0] TouchLenReset = 8'd66;

  typedef enum logic [1:0] {
    KindNone  = 2'd0,
    KindLen   = 2'd1,
    KindTouch = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StDiscard = 2'd0,
    StByte    = 2'd1,
    StLast    = 2'd2,
    StAbort   = 2'd3
  } status_e;

  typedef struct packed {
    logic       touch_enable;
    logic [7:0] touch_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic [7:0] position;
    status_e    status;
  } tag_t;

endpackage

`default_nettype wire

[sv/lpfs_rx_if.sv]
// ----------------------------------------------------------------------------
// lpfs_rx_if
// request channel carrying received serial bytes
// ----------------------------------------------------------------------------
`default_nettype none

interface lpfs_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[sv/lpfs_tag_if.sv]
// ----------------------------------------------------------------------------
// lpfs_tag_if
// request channel carrying tagged bytes
// ----------------------------------------------------------------------------
`default_nettype none

interface lpfs_tag_if;
  logic              valid;
  logic              ready;
  logic [7:0]        data;
  lpfs_pkg::kind_e   kind;
  logic [7:0]        position;
  lpfs_pkg::status_e status;

  modport source (output valid, output data, output kind, output position,
                  output status, input ready);
  modport sink   (input valid, input data, input kind, input position,
                  input status, output ready);
endinterface

`default_nettype wire

[sv/lpfs_tagger.sv]
// ----------------------------------------------------------------------------
// lpfs_tagger
// frame tracking state and the per-byte tagging logic
// ----------------------------------------------------------------------------
`default_nettype none

module lpfs_tagger (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [7:0]    byte_i,
  input  lpfs_pkg::cfg_t     cfg_i,
  output lpfs_pkg::tag_t     res_o
);

  lpfs_pkg::kind_e kind_q, kind_d;
  logic [7:0]      count_q, count_d;
  logic [15:0]     len_q, len_d;
  logic [8:0]      cnt_next;
  logic [15:0]     cnt_ext;

  assign cnt_next = {1'b0, count_q} + 9'd1;
  assign cnt_ext  = {7'd0, cnt_next};

  always_comb begin
    kind_d          = kind_q;
    count_d         = count_q;
    len_d           = len_q;
    res_o.data      = byte_i;
    res_o.kind      = lpfs_pkg::KindNone;
    res_o.position  = 8'd0;
    res_o.status    = lpfs_pkg::StDiscard;
    case (kind_q)
      lpfs_pkg::KindLen: begin
        res_o.kind     = lpfs_pkg::KindLen;
        res_o.position = count_q;
        if (count_q == 8'd1) begin
          len_d = {len_q[15:8], byte_i};
        end else if (count_q == 8'd2) begin
          len_d = {byte_i, len_q[7:0]};
        end
        if (cnt_ext < lpfs_pkg::JudgeCount) begin
          res_o.status = lpfs_pkg::StByte;
          count_d      = cnt_next[7:0];
        end else if (cnt_ext == lpfs_pkg::JudgeCount) begin
          if (len_d < lpfs_pkg::JudgeCount || len_d > lpfs_pkg::LargestLen) begin
            res_o.status = lpfs_pkg::StAbort;
            kind_d       = lpfs_pkg::KindNone;
            count_d      = 8'd0;
            len_d        = 16'd0;
          end else if (len_d == lpfs_pkg::JudgeCount) begin
            res_o.status = lpfs_pkg::StLast;
            kind_d       = lpfs_pkg::KindNone;
            count_d      = 8'd0;
            len_d        = 16'd0;
          end else begin
            res_o.status = lpfs_pkg::StByte;
            count_d      = cnt_next[7:0];
          end
        end else if (cnt_ext >= len_d) begin
          res_o.status = lpfs_pkg::StLast;
          kind_d       = lpfs_pkg::KindNone;
          count_d      = 8'd0;
          len_d        = 16'd0;
        end else begin
          res_o.status = lpfs_pkg::StByte;
          count_d      = cnt_next[7:0];
        end
      end
      lpfs_pkg::KindTouch: begin
        res_o.kind     = lpfs_pkg::KindTouch;
        res_o.position = count_q;
        if (cnt_next >= {1'b0, cfg_i.touch_len}) begin
          res_o.status = lpfs_pkg::StLast;
          kind_d       = lpfs_pkg::KindNone;
          count_d      = 8'd0;
          len_d        = 16'd0;
        end else begin
          res_o.status = lpfs_pkg::StByte;
          count_d      = cnt_next[7:0];
        end
      end
      default: begin
        // idle: look for a start byte
        kind_d  = lpfs_pkg::KindNone;
        count_d = 8'd0;
        len_d   = 16'd0;
        if (byte_i == lpfs_pkg::StartLen) begin
          res_o.kind   = lpfs_pkg::KindLen;
          res_o.status = lpfs_pkg::StByte;
          kind_d       = lpfs_pkg::KindLen;
          count_d      = 8'd1;
        end else if (byte_i == lpfs_pkg::StartTouch && cfg_i.touch_enable) begin
          res_o.kind = lpfs_pkg::KindTouch;
          if (cfg_i.touch_len <= 8'd1) begin
            res_o.status = lpfs_pkg::StLast;
          end else begin
            res_o.status = lpfs_pkg::StByte;
            kind_d       = lpfs_pkg::KindTouch;
            count_d      = 8'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= lpfs_pkg::KindNone;
      count_q <= 8'd0;
      len_q   <= 16'd0;
    end else if (step_i) begin
      kind_q  <= kind_d;
      count_q <= count_d;
      len_q   <= len_d;
    end
  end

endmodule

`default_nettype wire

[sv/length_prefixed_frame_splitter_unit.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_splitter_unit
// tags received serial bytes with their frame kind, position and status
// ----------------------------------------------------------------------------
// usage
//   rx_i takes one received byte per request; tag_o returns exactly one
//   tagged request per byte, in order: the byte itself, the frame kind,
//   its index inside the frame and a status (discarded, frame byte, last
//   byte of a good frame, frame aborted)
//   a 0xAA start byte opens a frame whose little-endian length sits in
//   bytes 1 and 2; the length is checked at the seventh byte, a 0x1F start
//   byte opens a touch frame of touch_len bytes when touch_enable is set
//   each accepted byte passes the input register, then the result register;
//   throughput: one byte per cycle while tag_o does not stall, as the
//   frame state updates once for each byte
//   reset clears the frame state to idle, empties both registers and sets
//   touch_enable to 1 and touch_len to 66
//   when the receiver stalls the result register holds; the input register
//   still takes one more byte, then rx_i.ready drops until tag_o drains
//   config writes are meant for idle periods only
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_splitter_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  lpfs_rx_if.sink                              rx_i,
  lpfs_tag_if.source                           tag_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [lpfs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [lpfs_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // result register
  logic           out_vld_q;
  lpfs_pkg::tag_t out_q;

  // config registers
  lpfs_pkg::cfg_t cfg_q;

  lpfs_pkg::tag_t res;
  logic           adv;

  // result register can take a new result when empty or being drained
  assign adv        = in_vld_q && (!out_vld_q || tag_o.ready);
  assign rx_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (tag_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.touch_enable <= 1'b1;
      cfg_q.touch_len    <= lpfs_pkg::TouchLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lpfs_pkg::CfgTouchEnable: cfg_q.touch_enable <= cfg_wdata_i[0];
        lpfs_pkg::CfgTouchLen:    cfg_q.touch_len    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // frame state and tagging, advances once per byte moved to the result
  lpfs_tagger u_tagger (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign tag_o.valid    = out_vld_q;
  assign tag_o.data     = out_q.data;
  assign tag_o.kind     = out_q.kind;
  assign tag_o.position = out_q.position;
  assign tag_o.status   = out_q.status;

  // an abort always lands on the seventh byte of a length-prefixed frame
  a_abort_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_o.valid && tag_o.status == lpfs_pkg::StAbort |->
      tag_o.kind == lpfs_pkg::KindLen && tag_o.position == 8'd6)
    else $error("abort result with wrong kind or position");

  // a discarded byte belongs to no frame
  a_discard_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_o.valid && tag_o.status == lpfs_pkg::StDiscard |->
      tag_o.kind == lpfs_pkg::KindNone && tag_o.position == 8'd0)
    else $error("discarded byte tagged with a frame");

  // an empty result register never holds off the sender
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tag_o.valid |-> rx_i.ready)
    else $error("input stalled with empty result register");

  // a result that moves in leaves valid set at the next edge
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_vld_q |=> tag_o.valid)
    else $error("result lost between stages");

endmodule

`default_nettype wire
